@@ sv/bitmap_block_allocator_macros.svh @@
// Assertion helpers for the bitmap allocator.
`ifndef BITMAP_BLOCK_ALLOCATOR_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS

`define BBA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bitmap allocator check failed");

`define BBA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bitmap allocator check failed");

`else

`define BBA_ASSERT_IMPL(lbl, ante, cons)
`define BBA_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ sv/bba_pkg.sv @@
package bba_pkg;

  localparam int MAP_BITS  = 256;
  localparam int MAP_COUNT = 2;

  localparam int WORD_BITS = 64;
  localparam int WORD_SH   = $clog2(WORD_BITS);
  localparam int MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int WIDX_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int ENTRIES   = MAP_COUNT * MAP_WORDS;
  localparam int ADDR_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam int OP_W     = 2;
  localparam int MAP_W    = 1;
  localparam int IDX_W    = 8;
  localparam int LIM_W    = 9;
  localparam int STATUS_W = 3;
  localparam int POS_W    = 8;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [OP_W-1:0] {
    OP_FIND  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK            = 3'd0,
    ST_NONE_FREE     = 3'd1,
    ST_ALREADY_SET   = 3'd2,
    ST_ALREADY_CLEAR = 3'd3,
    ST_RANGE         = 3'd4
  } status_e;

  // index of the lowest set bit
  function automatic logic [WORD_SH-1:0] lowest_set(input word_t v);
    logic [WORD_SH-1:0] r;
    r = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = WORD_SH'(i);
      end
    end
    return r;
  endfunction

endpackage

@@ sv/bitmap_block_allocator.sv @@
// Channel  Dir  tdata                                   tuser
// s_axis   in   [7:0] bit_index, [16:8] search_limit    [1:0] opcode, [2] map_select
// m_axis   out  [7:0] position                          [2:0] status
//
// Bitmaps sit in a word memory of 64-bit entries with a registered read port.
// Alloc and free step through accept, read, check and write back, and result; find
// reads, then checks one 64-bit word per step up to the limit. Nop, range errors
// and a zero-limit find go from accept to result. Reset clears per-word valid bits
// at once, so every bitmap reads as free. A stalled m_axis holds the result
// register; the next item is still taken and waits at its result step.
`include "bitmap_block_allocator_macros.svh"

module bitmap_block_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // [7:0] bit_index, [16:8] search_limit
  input  logic [2:0]  s_axis_tuser_i,   // [1:0] opcode, [2] map_select
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [7:0] position
  output logic [2:0]  m_axis_tuser_o    // [2:0] status
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_EV   = 4'b0100,
    S_RESP = 4'b1000
  } state_e;

  state_e state_q, state_d;

  bba_pkg::op_e                   op_q, op_d;
  logic [bba_pkg::MAP_W-1:0]      map_q, map_d;
  logic [bba_pkg::IDX_W-1:0]      idx_q, idx_d;
  logic [bba_pkg::LIM_W-1:0]      lim_q, lim_d;
  logic [bba_pkg::WIDX_W-1:0]     last_q, last_d;
  logic [bba_pkg::WIDX_W-1:0]     w_q, w_d;
  bba_pkg::status_e               res_st_q, res_st_d;
  logic [bba_pkg::POS_W-1:0]      res_pos_q, res_pos_d;

  logic                           out_valid_q, out_valid_d;
  bba_pkg::status_e               out_st_q, out_st_d;
  logic [bba_pkg::POS_W-1:0]      out_pos_q, out_pos_d;

  bba_pkg::word_t                 mem_q [bba_pkg::ENTRIES];
  logic [bba_pkg::ENTRIES-1:0]    valid_q, valid_d;
  bba_pkg::word_t                 rdata_q;
  logic                           rvalid_q;

  logic [bba_pkg::ADDR_W-1:0]     rd_addr, cur_addr;
  logic                           mem_we;
  bba_pkg::word_t                 mem_wdata;

  bba_pkg::op_e                   in_op;
  logic [bba_pkg::MAP_W-1:0]      in_map;
  logic [bba_pkg::IDX_W-1:0]      in_idx;
  logic [bba_pkg::LIM_W-1:0]      in_lim, in_lim_sat;
  logic                           map_bad, idx_bad;

  bba_pkg::word_t                 word_eff, lim_mask, free_bits, bit_mask;
  logic [bba_pkg::WORD_SH-1:0]    lsb_pos;
  logic [15:0]                    pos_full;

  assign in_op  = bba_pkg::op_e'(s_axis_tuser_i[1:0]);
  assign in_map = s_axis_tuser_i[2];
  assign in_idx = s_axis_tdata_i[7:0];
  assign in_lim = s_axis_tdata_i[16:8];

  assign in_lim_sat = (32'(in_lim) > bba_pkg::MAP_BITS) ?
                      bba_pkg::LIM_W'(bba_pkg::MAP_BITS) : in_lim;
  assign map_bad = 32'(in_map) >= bba_pkg::MAP_COUNT;
  assign idx_bad = 32'(in_idx) >= bba_pkg::MAP_BITS;

  assign cur_addr = bba_pkg::ADDR_W'(32'(map_q) * bba_pkg::MAP_WORDS + 32'(w_q));

  assign word_eff = rvalid_q ? rdata_q : '0;
  assign lim_mask = (w_q == last_q && lim_q[bba_pkg::WORD_SH-1:0] != '0) ?
                    ((bba_pkg::word_t'(1) << lim_q[bba_pkg::WORD_SH-1:0]) -
                     bba_pkg::word_t'(1)) : '1;
  assign free_bits = ~word_eff & lim_mask;
  assign lsb_pos   = bba_pkg::lowest_set(free_bits);
  assign pos_full  = (16'(w_q) << bba_pkg::WORD_SH) | 16'(lsb_pos);
  assign bit_mask  = bba_pkg::word_t'(1) << idx_q[bba_pkg::WORD_SH-1:0];

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_pos_q;
  assign m_axis_tuser_o  = out_st_q;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    map_d       = map_q;
    idx_d       = idx_q;
    lim_d       = lim_q;
    last_d      = last_q;
    w_d         = w_q;
    res_st_d    = res_st_q;
    res_pos_d   = res_pos_q;
    out_valid_d = out_valid_q;
    out_st_d    = out_st_q;
    out_pos_d   = out_pos_q;
    valid_d     = valid_q;
    mem_we      = 1'b0;
    mem_wdata   = word_eff;
    rd_addr     = cur_addr;

    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          op_d      = in_op;
          map_d     = in_map;
          idx_d     = in_idx;
          lim_d     = in_lim_sat;
          last_d    = bba_pkg::WIDX_W'((in_lim_sat - bba_pkg::LIM_W'(1)) >> bba_pkg::WORD_SH);
          w_d       = (in_op == bba_pkg::OP_FIND) ? '0 :
                      bba_pkg::WIDX_W'(in_idx >> bba_pkg::WORD_SH);
          res_st_d  = bba_pkg::ST_OK;
          res_pos_d = '0;
          if (in_op == bba_pkg::OP_NOP) begin
            state_d = S_RESP;
          end else if (map_bad) begin
            res_st_d = bba_pkg::ST_RANGE;
            state_d  = S_RESP;
          end else if (in_op == bba_pkg::OP_FIND) begin
            if (in_lim_sat == '0) begin
              res_st_d = bba_pkg::ST_NONE_FREE;
              state_d  = S_RESP;
            end else begin
              state_d = S_RD;
            end
          end else if (idx_bad) begin
            res_st_d = bba_pkg::ST_RANGE;
            state_d  = S_RESP;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        state_d = S_EV;
      end
      S_EV: begin
        // prefetch the following word for a find that keeps scanning
        rd_addr = bba_pkg::ADDR_W'(32'(map_q) * bba_pkg::MAP_WORDS +
                                   32'(w_q + bba_pkg::WIDX_W'(1)));
        case (op_q)
          bba_pkg::OP_FIND: begin
            if (free_bits != '0) begin
              res_st_d  = bba_pkg::ST_OK;
              res_pos_d = pos_full[bba_pkg::POS_W-1:0];
              state_d   = S_RESP;
            end else if (w_q == last_q) begin
              res_st_d = bba_pkg::ST_NONE_FREE;
              state_d  = S_RESP;
            end else begin
              w_d = w_q + bba_pkg::WIDX_W'(1);
            end
          end
          bba_pkg::OP_ALLOC: begin
            if ((word_eff & bit_mask) != '0) begin
              res_st_d = bba_pkg::ST_ALREADY_SET;
            end else begin
              mem_we            = 1'b1;
              mem_wdata         = word_eff | bit_mask;
              valid_d[cur_addr] = 1'b1;
            end
            state_d = S_RESP;
          end
          bba_pkg::OP_FREE: begin
            if ((word_eff & bit_mask) == '0) begin
              res_st_d = bba_pkg::ST_ALREADY_CLEAR;
            end else begin
              mem_we            = 1'b1;
              mem_wdata         = word_eff & ~bit_mask;
              valid_d[cur_addr] = 1'b1;
            end
            state_d = S_RESP;
          end
          default: begin
            state_d = S_RESP;
          end
        endcase
      end
      S_RESP: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_st_d    = res_st_q;
          out_pos_d   = res_pos_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      valid_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      valid_q     <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    map_q     <= map_d;
    idx_q     <= idx_d;
    lim_q     <= lim_d;
    last_q    <= last_d;
    w_q       <= w_d;
    res_st_q  <= res_st_d;
    res_pos_q <= res_pos_d;
    out_st_q  <= out_st_d;
    out_pos_q <= out_pos_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[cur_addr] <= mem_wdata;
    end
    rdata_q  <= mem_q[rd_addr];
    rvalid_q <= valid_q[rd_addr];
  end

  `BBA_ASSERT_NEXT(a_one_item, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o)
  `BBA_ASSERT_IMPL(a_write_in_eval, mem_we, state_q == S_EV && op_q != bba_pkg::OP_FIND)
  `BBA_ASSERT_NEXT(a_result_loaded,
                   state_q == S_RESP && (!out_valid_q || m_axis_tready_i), m_axis_tvalid_o)
  `BBA_ASSERT_IMPL(a_scan_bound, state_q == S_EV && op_q == bba_pkg::OP_FIND, w_q <= last_q)

endmodule

@@ tb/sv/testbench.sv @@
module testbench;

  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int RANDOM_ITEMS = 245;

  typedef struct {
    bba_pkg::op_e     op;
    bit               map;
    bit [7:0]         idx;
    bit [8:0]         lim;
  } req_t;

  typedef struct {
    bba_pkg::status_e st;
    bit [7:0]         pos;
  } outcome_t;

  typedef struct {
    bba_pkg::op_e     op;
    bit               map;
    bit [7:0]         idx;
    bit [8:0]         lim;
    bit               typed;
    bba_pkg::status_e st;
    bit [7:0]         pos;
  } step_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [23:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tready = 1'b0;
  logic        s_tready;
  logic        m_tvalid;
  logic [7:0]  m_tdata;
  logic [2:0]  m_tuser;

  bit [bba_pkg::MAP_BITS-1:0] used_map [bba_pkg::MAP_COUNT];
  outcome_t          outcome_q [$];
  int                mismatch_cnt = 0;
  int                burst_left = 8;
  bit                hold_req = 1'b0;
  int unsigned       cycle_cnt = 0;

  // Directed steps: empty maps, limit extremes, every reachable error status, nop.
  step_t steps [24] = '{
    '{bba_pkg::OP_FIND,  1'b0, 8'd0,   9'd256, 1'b1, bba_pkg::ST_OK,            8'd0},
    '{bba_pkg::OP_FIND,  1'b0, 8'd255, 9'd0,   1'b1, bba_pkg::ST_NONE_FREE,     8'd0},
    '{bba_pkg::OP_FIND,  1'b1, 8'd0,   9'd511, 1'b1, bba_pkg::ST_OK,            8'd0},
    '{bba_pkg::OP_FREE,  1'b0, 8'd0,   9'd0,   1'b1, bba_pkg::ST_ALREADY_CLEAR, 8'd0},
    '{bba_pkg::OP_ALLOC, 1'b0, 8'd0,   9'd511, 1'b1, bba_pkg::ST_OK,            8'd0},
    '{bba_pkg::OP_ALLOC, 1'b0, 8'd0,   9'd0,   1'b1, bba_pkg::ST_ALREADY_SET,   8'd0},
    '{bba_pkg::OP_FIND,  1'b0, 8'd0,   9'd1,   1'b1, bba_pkg::ST_NONE_FREE,     8'd0},
    '{bba_pkg::OP_FIND,  1'b0, 8'd0,   9'd256, 1'b1, bba_pkg::ST_OK,            8'd1},
    '{bba_pkg::OP_ALLOC, 1'b1, 8'd255, 9'd256, 1'b1, bba_pkg::ST_OK,            8'd0},
    '{bba_pkg::OP_ALLOC, 1'b1, 8'd255, 9'd0,   1'b1, bba_pkg::ST_ALREADY_SET,   8'd0},
    '{bba_pkg::OP_FREE,  1'b1, 8'd255, 9'd0,   1'b1, bba_pkg::ST_OK,            8'd0},
    '{bba_pkg::OP_FREE,  1'b1, 8'd255, 9'd511, 1'b1, bba_pkg::ST_ALREADY_CLEAR, 8'd0},
    '{bba_pkg::OP_NOP,   1'b1, 8'd255, 9'd511, 1'b1, bba_pkg::ST_OK,            8'd0},
    '{bba_pkg::OP_NOP,   1'b0, 8'd0,   9'd0,   1'b1, bba_pkg::ST_OK,            8'd0},
    '{bba_pkg::OP_ALLOC, 1'b0, 8'd1,   9'd0,   1'b1, bba_pkg::ST_OK,            8'd0},
    '{bba_pkg::OP_ALLOC, 1'b0, 8'd2,   9'd0,   1'b0, bba_pkg::ST_OK,            8'd0},
    '{bba_pkg::OP_FIND,  1'b0, 8'd0,   9'd3,   1'b1, bba_pkg::ST_NONE_FREE,     8'd0},
    '{bba_pkg::OP_FIND,  1'b0, 8'd0,   9'd4,   1'b0, bba_pkg::ST_OK,            8'd0},
    '{bba_pkg::OP_ALLOC, 1'b0, 8'd170, 9'd0,   1'b0, bba_pkg::ST_OK,            8'd0},
    '{bba_pkg::OP_ALLOC, 1'b0, 8'd85,  9'd0,   1'b0, bba_pkg::ST_OK,            8'd0},
    '{bba_pkg::OP_FREE,  1'b0, 8'd1,   9'd0,   1'b0, bba_pkg::ST_OK,            8'd0},
    '{bba_pkg::OP_FIND,  1'b0, 8'd0,   9'd257, 1'b0, bba_pkg::ST_OK,            8'd0},
    '{bba_pkg::OP_FIND,  1'b1, 8'd0,   9'd255, 1'b0, bba_pkg::ST_OK,            8'd0},
    '{bba_pkg::OP_FREE,  1'b0, 8'd170, 9'd0,   1'b0, bba_pkg::ST_OK,            8'd0}
  };

  bitmap_block_allocator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Applies one operation to the bitmap shadow; finds leave it untouched.
  function automatic outcome_t bitmap_outcome(req_t r);
    outcome_t o;
    int top;
    o.st = bba_pkg::ST_OK;
    o.pos = '0;
    if (r.op == bba_pkg::OP_NOP) begin
      o.st = bba_pkg::ST_OK;
    end else if (int'(r.map) >= bba_pkg::MAP_COUNT) begin
      o.st = bba_pkg::ST_RANGE;
    end else if (r.op == bba_pkg::OP_FIND) begin
      top = (int'(r.lim) > bba_pkg::MAP_BITS) ? bba_pkg::MAP_BITS : int'(r.lim);
      o.st = bba_pkg::ST_NONE_FREE;
      for (int p = 0; p < top; p++) begin
        if (!used_map[r.map][p]) begin
          o.st = bba_pkg::ST_OK;
          o.pos = p[7:0];
          break;
        end
      end
    end else if (int'(r.idx) >= bba_pkg::MAP_BITS) begin
      o.st = bba_pkg::ST_RANGE;
    end else if (r.op == bba_pkg::OP_ALLOC) begin
      if (used_map[r.map][r.idx]) begin
        o.st = bba_pkg::ST_ALREADY_SET;
      end else begin
        used_map[r.map][r.idx] = 1'b1;
      end
    end else begin
      if (!used_map[r.map][r.idx]) begin
        o.st = bba_pkg::ST_ALREADY_CLEAR;
      end else begin
        used_map[r.map][r.idx] = 1'b0;
      end
    end
    return o;
  endfunction

  task automatic send_req(req_t r, bit typed, outcome_t want);
    outcome_t got;
    s_valid <= 1'b1;
    s_tdata <= {7'b0, r.lim, r.idx};
    s_tuser <= {r.map, r.op};
    do @(posedge clk_i); while (!s_tready);
    got = bitmap_outcome(r);
    outcome_q.push_back(typed ? want : got);
    burst_left--;
    if (burst_left <= 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 16);
    end
  endtask

  task automatic wait_settled();
    s_valid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic req_t noise_req();
    req_t r;
    r.op = bba_pkg::op_e'(2'($urandom_range(0, 3)));
    r.map = 1'($urandom_range(0, 1));
    r.idx = 8'($urandom_range(0, 255));
    r.lim = 9'($urandom_range(0, 511));
    return r;
  endfunction

  // stimulus
  initial begin
    req_t r;
    outcome_t w;
    outcome_t peek;
    int start;
    w.st = bba_pkg::ST_OK;
    w.pos = '0;
    for (int m = 0; m < bba_pkg::MAP_COUNT; m++) used_map[m] = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (steps[i]) begin
      r.op = steps[i].op;
      r.map = steps[i].map;
      r.idx = steps[i].idx;
      r.lim = steps[i].lim;
      w.st = steps[i].st;
      w.pos = steps[i].pos;
      send_req(r, steps[i].typed, w);
    end
    wait_settled();

    // fill map 1 completely, then probe it full and reopen a hole
    for (int j = 0; j < bba_pkg::MAP_BITS; j++) begin
      r.op = bba_pkg::OP_ALLOC;
      r.map = 1'b1;
      r.idx = j[7:0];
      r.lim = 9'($urandom_range(0, 511));
      send_req(r, 1'b0, w);
    end
    r.op = bba_pkg::OP_FIND;
    r.lim = 9'd256;
    send_req(r, 1'b0, w);
    r.lim = 9'd511;
    send_req(r, 1'b0, w);
    r.op = bba_pkg::OP_FREE;
    r.idx = 8'($urandom_range(0, 255));
    send_req(r, 1'b0, w);
    r.op = bba_pkg::OP_FIND;
    r.lim = 9'd256;
    send_req(r, 1'b0, w);
    wait_settled();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 120) hold_req = 1'b1;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          // claim: find a free slot, then allocate it
          r.op = bba_pkg::OP_FIND;
          r.map = 1'($urandom_range(0, 1));
          r.idx = 8'($urandom_range(0, 255));
          r.lim = ($urandom_range(0, 2) == 0) ? 9'($urandom_range(0, 511)) : 9'd256;
          peek = bitmap_outcome(r);
          if (peek.st == bba_pkg::ST_OK && $urandom_range(0, 2) != 0 &&
              int'(peek.pos) < 255) begin
            r.lim = 9'(int'(peek.pos) + $urandom_range(1, 2));
          end
          send_req(r, 1'b0, w);
          peek = bitmap_outcome(r);
          r.op = bba_pkg::OP_ALLOC;
          r.idx = (peek.st == bba_pkg::ST_OK) ? peek.pos : 8'($urandom_range(0, 255));
          send_req(r, 1'b0, w);
        end
        5, 6: begin
          // release some used position, scanning from a random start
          r.op = bba_pkg::OP_FREE;
          r.map = 1'($urandom_range(0, 1));
          r.lim = 9'($urandom_range(0, 511));
          start = $urandom_range(0, bba_pkg::MAP_BITS - 1);
          r.idx = 8'(start);
          for (int k = 0; k < bba_pkg::MAP_BITS; k++) begin
            if (used_map[r.map][(start + k) % bba_pkg::MAP_BITS]) begin
              r.idx = 8'((start + k) % bba_pkg::MAP_BITS);
              break;
            end
          end
          send_req(r, 1'b0, w);
        end
        default: begin
          send_req(noise_req(), 1'b0, w);
        end
      endcase
      if (n == 200) wait_settled();
    end

    wait_settled();
    if (mismatch_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // result side: stall pattern changes per segment, plus one long hold-off
  initial begin
    int seg;
    int mode;
    int k;
    wait (rst_ni === 1'b1);
    forever begin
      seg = $urandom_range(16, 96);
      mode = $urandom_range(0, 3);
      k = $urandom_range(2, 5);
      for (int c = 0; c < seg; c++) begin
        @(posedge clk_i);
        if (hold_req) begin
          m_tready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk_i);
          hold_req = 1'b0;
        end
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= (c % k == 0);
          default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      if (outcome_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
          $display("unexpected transfer: status %0d position %0d", m_tuser, m_tdata);
        end
      end else begin
        want = outcome_q.pop_front();
        if (m_tuser !== want.st || m_tdata !== want.pos) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("mismatch: status exp %0d got %0d, position exp %0d got %0d",
                     want.st, m_tuser, want.pos, m_tdata);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", outcome_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule
